>>> rtl/core/four_corner_trajectory_panner_macros.svh
// Assertion macros for the four-corner trajectory panner
`ifndef FOUR_CORNER_TRAJECTORY_PANNER_MACROS_SVH
`define FOUR_CORNER_TRAJECTORY_PANNER_MACROS_SVH
`ifndef SYNTHESIS
`define FCTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define FCTP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define FCTP_ASSERT(lbl, clk, rst_n, prop)
`define FCTP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/core/fctp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctp_pkg
// Shared constants, types and Mitchell helpers of the trajectory panner.
// ----------------------------------------------------------------------------
package fctp_pkg;

  localparam int FracBitsDef = 16;
  localparam int CfgW   = 17;
  localparam int CurveW = 16;
  localparam int PhaseW = 19;
  localparam int OffW   = 18;
  localparam int CfW    = 18;
  localparam int Log2eQ16 = 94548;
  localparam int CurveMax = 262143;

  localparam logic [2:0] RegStartX = 3'd0;
  localparam logic [2:0] RegStartY = 3'd1;
  localparam logic [2:0] RegEndX   = 3'd2;
  localparam logic [2:0] RegEndY   = 3'd3;
  localparam logic [2:0] RegCurve  = 3'd4;

  // datapath commands
  typedef enum logic [2:0] {
    CmdNone, CmdLoad, CmdPow, CmdPoint, CmdSq, CmdRoot, CmdStore
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] corner;
  } ctl_t;

  // exp(s): s Q4.12 (17-bit signed sum), result Q6.12 saturated
  function automatic logic [CfW-1:0] mitchell_exp(input logic signed [16:0] s);
    logic signed [35:0] prod;
    logic signed [19:0] t;
    logic signed [7:0]  k;
    logic [12:0]        base;
    logic [CfW-1:0]     r;
    prod = 36'(s) * 36'sd94548;
    t    = 20'(prod >>> 16);
    k    = 8'(t >>> 12);
    base = {1'b1, t[11:0]};
    if (k >= 8'sd6) r = CfW'(CurveMax);
    else if (k >= 8'sd0) r = CfW'({5'd0, base} << k[2:0]);
    else if (k <= -8'sd14) r = '0;
    else r = CfW'(base >> 4'(-k));
    return r;
  endfunction

endpackage

>>> rtl/core/fctp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctp_stream_if
// Valid/ready channel carrying one generic payload beat.
// ----------------------------------------------------------------------------
interface fctp_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/four_corner_trajectory_panner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_corner_trajectory_panner
// Phase-driven point on a curved path, four corner distance gains.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one phase beat with five offsets; out_ch returns one
// beat of four Q1.16 gains {bottom, far, right, origin} (origin in low bits).
// A phase below the previous one latches a new path from the APB registers
// plus the beat's offsets. Each beat goes from accept to output valid through
// load, warp, point, then square and root per corner through one
// shared sequencer, plus the output store. The next beat is accepted the
// cycle after the store, so no new beat is taken before the last is stored.
// A result waits in the output register while the sink stalls; the next
// beat is processed meanwhile and held at the store step until it drains.
// Reset clears registers to zero, last phase to one and curve factor to one.
// ----------------------------------------------------------------------------
`include "four_corner_trajectory_panner_macros.svh"
module four_corner_trajectory_panner
  import fctp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fctp_stream_if.sink   in_ch,
  fctp_stream_if.source out_ch
);
  logic [CfgW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [CurveW-1:0] cl_q;
  logic [2:0] ridx;
  ctl_t ctl;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0; cl_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegStartX: sx_q <= pwdata[CfgW-1:0];
        RegStartY: sy_q <= pwdata[CfgW-1:0];
        RegEndX:   ex_q <= pwdata[CfgW-1:0];
        RegEndY:   ey_q <= pwdata[CfgW-1:0];
        RegCurve:  cl_q <= pwdata[CurveW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegStartX: prdata = 32'(sx_q);
      RegStartY: prdata = 32'(sy_q);
      RegEndX:   prdata = 32'(ex_q);
      RegEndY:   prdata = 32'(ey_q);
      RegCurve:  prdata = 32'(cl_q);
      default:   prdata = '0;
    endcase
  end

  fctp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .ctl_o      (ctl)
  );

  fctp_datapath u_dp (
    .clk_i, .rst_ni,
    .ctl_i      (ctl),
    .start_x_i  (sx_q), .start_y_i(sy_q), .end_x_i(ex_q), .end_y_i(ey_q),
    .curve_log_i(cl_q),
    .phase_i    (in_ch.data[18:0]),
    .off_sx_i   (in_ch.data[36:19]),
    .off_sy_i   (in_ch.data[54:37]),
    .off_ex_i   (in_ch.data[72:55]),
    .off_ey_i   (in_ch.data[90:73]),
    .off_curve_i(in_ch.data[106:91]),
    .gains_o    (out_ch.data)
  );

  `FCTP_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(in_ch.ready && ctl.cmd == CmdStore))
  `FCTP_ASSERT_NEXT(a_store_valid, clk_i, rst_ni, ctl.cmd == CmdStore, out_ch.valid)
  `FCTP_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, ctl.cmd == CmdLoad, !in_ch.ready)
endmodule

>>> rtl/core/fctp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctp_ctrl
// Sequencer: steps the datapath through one item, hands off the result.
// ----------------------------------------------------------------------------
module fctp_ctrl
  import fctp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ctl_t ctl_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SPow   = 3'd1;
  localparam logic [2:0] SPoint = 3'd2;
  localparam logic [2:0] SSq    = 3'd3;
  localparam logic [2:0] SRoot  = 3'd4;
  localparam logic [2:0] SStore = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] corner_q, corner_d;
  logic       ov_q, ov_d;

  // input taken when idle; output register frees before store
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    ov_d     = ov_q && !out_ready_i;
    ctl_o.cmd    = CmdNone;
    ctl_o.corner = corner_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ctl_o.cmd = CmdLoad;
          state_d   = SPow;
        end
      end
      SPow: begin
        ctl_o.cmd = CmdPow;
        state_d   = SPoint;
      end
      SPoint: begin
        ctl_o.cmd = CmdPoint;
        corner_d  = 2'd0;
        state_d   = SSq;
      end
      SSq: begin
        ctl_o.cmd = CmdSq;
        state_d   = SRoot;
      end
      SRoot: begin
        ctl_o.cmd = CmdRoot;
        corner_d  = corner_q + 2'd1;
        state_d   = (corner_q == 2'd3) ? SStore : SSq;
      end
      SStore: begin
        if (!ov_q || out_ready_i) begin
          ctl_o.cmd = CmdStore;
          ov_d      = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      corner_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
      ov_q     <= ov_d;
    end
  end
endmodule

>>> rtl/core/fctp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctp_datapath
// Trajectory state, phase warp, point and per-corner distance gains.
// ----------------------------------------------------------------------------
module fctp_datapath
  import fctp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  logic [CfgW-1:0] start_x_i,
  input  logic [CfgW-1:0] start_y_i,
  input  logic [CfgW-1:0] end_x_i,
  input  logic [CfgW-1:0] end_y_i,
  input  logic signed [CurveW-1:0] curve_log_i,
  input  logic signed [PhaseW-1:0] phase_i,
  input  logic signed [OffW-1:0] off_sx_i,
  input  logic signed [OffW-1:0] off_sy_i,
  input  logic signed [OffW-1:0] off_ex_i,
  input  logic signed [OffW-1:0] off_ey_i,
  input  logic signed [CurveW-1:0] off_curve_i,
  output logic [4*CfgW-1:0] gains_o
);
  localparam int FracBits = FracBitsDef;
  localparam int CW = FracBits + 1;     // coordinate width, holds one
  localparam int MW = FracBits + 2;     // signed move width
  localparam int XW = FracBits + 3;     // pow argument, below 2^(F+2)
  localparam int PW = $clog2(XW);
  localparam int PrW = MW + CW + 10;    // move times warp, full product
  localparam logic [CW-1:0] One = CW'(1) << FracBits;

  function automatic logic [CW-1:0] clampu(input logic signed [XW+1:0] v);
    logic [CW-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({2'b0, XW'(One)})) r = One;
    else r = CW'(v);
    return r;
  endfunction

  // Mitchell x^e: x < 2^(F+2), e unsigned Q12
  function automatic logic [CW+8:0] mpow(input logic [XW-1:0] x,
                                         input logic [CfW-1:0] e);
    logic [PW-1:0]            p;
    logic [XW+FracBits-1:0]   fr;
    logic signed [XW+PW+1:0]  lg;
    logic signed [XW+PW+CfW+2:0] m;
    logic signed [XW+PW+CfW+2:0] k;
    logic [CW-1:0]            base;
    logic [CW+8:0]            r;
    p = '0;
    for (int i = 0; i < XW; i++) if (x[i]) p = PW'(i);
    fr = ({FracBits'(0), x} - ({FracBits'(0), XW'(1)} << p)) << FracBits;
    fr = fr >> p;
    lg = $signed((XW+PW+2)'(p)) - $signed((XW+PW+2)'(FracBits));
    lg = (lg <<< FracBits) + $signed((XW+PW+2)'(fr[FracBits-1:0]));
    m  = ($signed((XW+PW+CfW+3)'(lg)) * $signed({1'b0, e})) >>> 12;
    k  = m >>> FracBits;
    base = One | CW'(m[FracBits-1:0]);
    if (x == '0) r = '0;
    else if (k >= 0) r = (CW+9)'(base) << ((k > 8) ? 4'd8 : 4'(k));
    else if (k <= -(CW+9)) r = '0;
    else r = (CW+9)'(base) >> (-k);
    return r;
  endfunction

  logic [CW-1:0] last_q, fsx_q, fsy_q, phase_q;
  logic signed [MW-1:0] mvx_q, mvy_q;
  logic [CfW-1:0] cf_q;
  logic [CW+8:0] d_q;
  logic [CW-1:0] px_q, py_q;
  logic [XW-1:0] sq_q;
  logic [CW-1:0] g_q [4];

  logic [CW-1:0] ph_c, sx_c, sy_c, ex_c, ey_c;
  logic [CW-1:0] dx_c, dy_c;
  logic [CW+8:0] root_c;

  always_comb begin
    ph_c = clampu((XW+2)'(phase_i));
    sx_c = clampu($signed({2'b0, XW'(clampu((XW+2)'(start_x_i)))}) + (XW+2)'(off_sx_i));
    sy_c = clampu($signed({2'b0, XW'(clampu((XW+2)'(start_y_i)))}) + (XW+2)'(off_sy_i));
    ex_c = clampu($signed({2'b0, XW'(clampu((XW+2)'(end_x_i)))}) + (XW+2)'(off_ex_i));
    ey_c = clampu($signed({2'b0, XW'(clampu((XW+2)'(end_y_i)))}) + (XW+2)'(off_ey_i));
    dx_c = ctl_i.corner[0] ^ ctl_i.corner[1] ? One - px_q : px_q;
    dy_c = ctl_i.corner[1] ? One - py_q : py_q;
    root_c = mpow(sq_q, CfW'(2048));
  end

  // one step per command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= One;
      fsx_q  <= '0;
      fsy_q  <= '0;
      mvx_q  <= '0;
      mvy_q  <= '0;
      cf_q   <= CfW'(4096);
    end else if (ctl_i.cmd == CmdLoad) begin
      last_q <= ph_c;
      if (ph_c < last_q) begin
        fsx_q <= sx_c;
        fsy_q <= sy_c;
        mvx_q <= $signed({1'b0, ex_c}) - $signed({1'b0, sx_c});
        mvy_q <= $signed({1'b0, ey_c}) - $signed({1'b0, sy_c});
        cf_q  <= mitchell_exp(17'(curve_log_i) + 17'(off_curve_i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdLoad:  phase_q <= ph_c;
      CmdPow:   d_q <= mpow(XW'(phase_q), cf_q);
      CmdPoint: begin
        px_q <= clampu((XW+2)'(fsx_q) +
                (XW+2)'(($signed(PrW'(mvx_q)) * $signed(PrW'({1'b0, d_q})))
                        >>> FracBits));
        py_q <= clampu((XW+2)'(fsy_q) +
                (XW+2)'(($signed(PrW'(mvy_q)) * $signed(PrW'({1'b0, d_q})))
                        >>> FracBits));
      end
      CmdSq: sq_q <= XW'(((2*CW)'(dx_c) * (2*CW)'(dx_c)) >> FracBits) +
                     XW'(((2*CW)'(dy_c) * (2*CW)'(dy_c)) >> FracBits);
      CmdRoot: g_q[ctl_i.corner] <= (root_c >= (CW+9)'(One)) ? '0
                                    : CW'((CW+9)'(One) - root_c);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CmdStore)
      gains_o <= {CfgW'(g_q[3]), CfgW'(g_q[2]), CfgW'(g_q[1]), CfgW'(g_q[0])};
  end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the four-corner trajectory panner against a behavioral predictor:
// sawtooth phase streams with random offsets, several register settings,
// random idling on both channels and a field-by-field check of every gain.
// ----------------------------------------------------------------------------
module testbench;
  import fctp_pkg::*;

  localparam int InW    = PhaseW + 4 * OffW + CurveW;
  localparam int OutW   = 4 * CfgW;
  localparam longint Unit = 64'sd65536;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [CurveW-1:0] curve;
    logic signed [OffW-1:0]   end_y;
    logic signed [OffW-1:0]   end_x;
    logic signed [OffW-1:0]   start_y;
    logic signed [OffW-1:0]   start_x;
    logic signed [PhaseW-1:0] phase;
  } beat_t;

  typedef struct packed {
    logic [CfgW-1:0] bottom;
    logic [CfgW-1:0] far;
    logic [CfgW-1:0] right;
    logic [CfgW-1:0] origin;
  } gains_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fctp_stream_if #(.W(InW))  in_ch ();
  fctp_stream_if #(.W(OutW)) out_ch ();

  four_corner_trajectory_panner dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of registers and path state
  longint cfg_sx, cfg_sy, cfg_ex, cfg_ey, cfg_curve;
  longint prev_phase, path_sx, path_sy, path_mx, path_my, warp_exp;

  beat_t  pending_beats[$];
  gains_t expected_gains[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > Unit) return Unit;
    return v;
  endfunction

  function automatic longint curve_exp(longint s);
    longint t, k, base;
    t = (s * 94548) >>> 16;
    k = t >>> 12;
    base = 4096 + (t & 4095);
    if (k >= 6) return 262143;
    if (k >= 0) return base << k;
    if (k <= -14) return 0;
    return base >>> (-k);
  endfunction

  // Mitchell log2, scale, antilog2
  function automatic longint approx_pow(longint x, longint e);
    int p;
    longint frac, lg, m, k, base;
    if (x <= 0) return 0;
    p = 0;
    while ((x >> (p + 1)) != 0) p++;
    frac = ((x - (64'sd1 << p)) << 16) >> p;
    lg = (p - 16) * Unit + frac;
    m = (lg * e) >>> 12;
    k = m >>> 16;
    base = Unit + (m & (Unit - 1));
    if (k >= 0) begin
      if (k > 8) k = 8;
      return base << k;
    end
    if (k <= -62) return 0;
    return base >>> (-k);
  endfunction

  function automatic logic [CfgW-1:0] corner_level(longint dx, longint dy);
    longint sq, g;
    sq = ((dx * dx) >>> 16) + ((dy * dy) >>> 16);
    g = Unit - approx_pow(sq, 2048);
    if (g < 0) g = 0;
    return CfgW'(g);
  endfunction

  function automatic gains_t pan_gains(beat_t b);
    longint ph, d, px, py, ex, ey;
    gains_t g;
    ph = unit_clamp(longint'(b.phase));
    if (ph < prev_phase) begin
      path_sx = unit_clamp(unit_clamp(cfg_sx) + longint'(b.start_x));
      path_sy = unit_clamp(unit_clamp(cfg_sy) + longint'(b.start_y));
      ex = unit_clamp(unit_clamp(cfg_ex) + longint'(b.end_x));
      ey = unit_clamp(unit_clamp(cfg_ey) + longint'(b.end_y));
      path_mx = ex - path_sx;
      path_my = ey - path_sy;
      warp_exp = curve_exp(cfg_curve + longint'(b.curve));
    end
    d = approx_pow(ph, warp_exp);
    px = unit_clamp(path_sx + ((path_mx * d) >>> 16));
    py = unit_clamp(path_sy + ((path_my * d) >>> 16));
    g.origin = corner_level(px, py);
    g.right  = corner_level(Unit - px, py);
    g.far    = corner_level(Unit - px, Unit - py);
    g.bottom = corner_level(px, Unit - py);
    prev_phase = ph;
    return g;
  endfunction

  // input driver with random gap bursts
  int in_gap = 0;
  always @(posedge clk_i) begin
    beat_t nb;
    logic  nv;
    nv = in_ch.valid;
    nb = in_ch.data;
    if (in_ch.valid && in_ch.ready) begin
      expected_gains.push_back(pan_gains(beat_t'(in_ch.data)));
      nv = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_beats.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 2);
        end else begin
          nb = pending_beats.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_ch.valid <= nv;
    in_ch.data  <= nb;
  end

  // output monitor: random stalls and gain check
  int out_gap = 0;
  always @(posedge clk_i) begin
    gains_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = gains_t'(out_ch.data);
      if (expected_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected gain beat %h", got);
      end else begin
        want = expected_gains.pop_front();
        if (got.origin !== want.origin || got.right !== want.right ||
            got.far !== want.far || got.bottom !== want.bottom) begin
          mismatches++;
          if (mismatches <= 10)
            $display("gain mismatch: exp o=%0d r=%0d f=%0d b=%0d got o=%0d r=%0d f=%0d b=%0d",
                     want.origin, want.right, want.far, want.bottom,
                     got.origin, got.right, got.far, got.bottom);
        end
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * idx); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (3'(idx))
      RegStartX: cfg_sx = longint'(value[16:0]);
      RegStartY: cfg_sy = longint'(value[16:0]);
      RegEndX:   cfg_ex = longint'(value[16:0]);
      RegEndY:   cfg_ey = longint'(value[16:0]);
      RegCurve:  cfg_curve = longint'(signed'(value[15:0]));
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] sx, sy, ex, ey, cv);
    reg_write(RegStartX, sx);
    reg_write(RegStartY, sy);
    reg_write(RegEndX, ex);
    reg_write(RegEndY, ey);
    reg_write(RegCurve, cv);
  endtask

  // wait for every beat to drain, then let the pipeline settle
  task automatic drain();
    while (pending_beats.size() > 0 || in_ch.valid || expected_gains.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic beat_t make_beat(int ph, int o1, o2, o3, o4, oc);
    beat_t b;
    b.phase = PhaseW'(ph);
    b.start_x = OffW'(o1); b.start_y = OffW'(o2);
    b.end_x = OffW'(o3); b.end_y = OffW'(o4);
    b.curve = CurveW'(oc);
    return b;
  endfunction

  function automatic int rnd_off();
    if ($urandom_range(0, 2) == 0) return int'($urandom_range(0, 131072)) - 65536;
    return int'($urandom_range(0, 16384)) - 8192;
  endfunction

  // directed corners of the fields
  task automatic push_directed();
    pending_beats.push_back(make_beat(0, 0, 0, 65536, 65536, 0));
    pending_beats.push_back(make_beat(32768, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(65536, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(131072, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(-65536, 65536, 65536, -65536, -65536, 16384));
    pending_beats.push_back(make_beat(1, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(65535, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(100, -65536, -65536, 65536, 65536, -16384));
    pending_beats.push_back(make_beat(40000, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(20000, 12345, -54321, 30000, 65536, 16384));
    pending_beats.push_back(make_beat(60000, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(-1, -3, 7, 65536, -65536, -1));
    pending_beats.push_back(make_beat(131071, 0, 0, 0, 0, 0));
  endtask

  // sawtooth phase runs, with some arbitrary noise beats
  task automatic push_random(input int count);
    int ph;
    ph = 0;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_beats.push_back(make_beat(int'($urandom_range(0, 196608)) - 65536,
                                          rnd_off(), rnd_off(), rnd_off(), rnd_off(),
                                          int'($urandom_range(0, 32768)) - 16384));
      end else begin
        ph += int'($urandom_range(1, 12000));
        if (ph > 65536 + 2000) ph = int'($urandom_range(0, 3000));
        pending_beats.push_back(make_beat(ph, rnd_off(), rnd_off(), rnd_off(), rnd_off(),
                                          int'($urandom_range(0, 32768)) - 16384));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_sx = 0; cfg_sy = 0; cfg_ex = 0; cfg_ey = 0; cfg_curve = 0;
    prev_phase = Unit; path_sx = 0; path_sy = 0; path_mx = 0; path_my = 0;
    warp_exp = 4096;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // reset values, then the extremes
    push_directed();
    drain();
    write_all(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'h0000_4000);
    push_directed();
    drain();
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_C000);
    push_directed();
    push_random(100);
    drain();
    // unmapped address must be ignored; wide values exercise masking and clamps
    reg_write(6, $urandom());
    write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    push_random(150);
    drain();
    repeat (3) begin
      write_all($urandom_range(0, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom_range(0, 65536),
                32'(int'($urandom_range(0, 32768)) - 16384));
      push_random(180);
      drain();
    end
    // last stretch without idling
    quiet = 1'b1;
    write_all(32'd0, 32'd65536, 32'd65536, 32'd0, 32'd0);
    push_random(150);
    drain();

    if (mismatches == 0 && expected_gains.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
